FILE: rtl/tauv_pkg.sv
// Shared types and constants for the tile atlas rectangle block.
// No dependencies; tauv_front, tauv_back and the top level use this package.
package tauv_pkg;

	// field widths fixed by the register map and result format
	localparam int CFG_W    = 12;
	localparam int TEX_W    = 15;
	localparam int PX_W     = 15;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 5;
	localparam int DIV_BPS  = 2;   // quotient bits resolved per divider stage

	// defaults for the top level parameters
	localparam int DEF_TILE_ID_BITS    = 16;
	localparam int DEF_MAX_TEXTURE_DIM = 16384;
	localparam int DEF_FRACTION_BITS   = 16;

	// register index (paddr[4:2])
	localparam logic [2:0] REG_TILE_WIDTH     = 3'd0;
	localparam logic [2:0] REG_TILE_HEIGHT    = 3'd1;
	localparam logic [2:0] REG_GRID_COLUMNS   = 3'd2;
	localparam logic [2:0] REG_GRID_ROWS      = 3'd3;
	localparam logic [2:0] REG_EDGE_MARGIN    = 3'd4;
	localparam logic [2:0] REG_TILE_GAP       = 3'd5;
	localparam logic [2:0] REG_TEXTURE_WIDTH  = 3'd6;
	localparam logic [2:0] REG_TEXTURE_HEIGHT = 3'd7;

	typedef struct packed {
		logic [CFG_W-1:0] tile_width;
		logic [CFG_W-1:0] tile_height;
		logic [CFG_W-1:0] grid_columns;
		logic [CFG_W-1:0] grid_rows;
		logic [CFG_W-1:0] edge_margin;
		logic [CFG_W-1:0] tile_gap;
		logic [TEX_W-1:0] texture_width;
		logic [TEX_W-1:0] texture_height;
	} cfg_t;

endpackage

FILE: rtl/tauv_fifo.sv
// Small flop-based word queue with occupancy count.
// Depends on nothing; depth must be a power of two.
module tauv_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [W-1:0]               din,
	input  logic                       pop,
	output logic [W-1:0]               dout,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] cnt_q;

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push && pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= din;
	end

	assign dout  = mem_q[rp_q];
	assign count = cnt_q;

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && cnt_q == CW'(DEPTH)))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && cnt_q == '0))
		else $error("queue read while empty");
`endif
endmodule

FILE: rtl/tauv_div.sv
// Pipelined restoring divider, NL lanes sharing one valid and sideband.
// Uses DIV_BPS-style stepping set by BPS; no package dependency.
module tauv_div #(
	parameter int NL  = 1,
	parameter int VW  = 12,
	parameter int QW  = 16,
	parameter int BPS = 2,
	parameter int PW  = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [NL-1:0][VW-1:0]  in_rem,
	input  logic [NL-1:0][QW-1:0]  in_dq,
	input  logic [NL-1:0][VW-1:0]  in_dvs,
	input  logic [PW-1:0]          in_pay,
	output logic                   out_valid,
	output logic [NL-1:0][QW-1:0]  out_quo,
	output logic [NL-1:0][VW-1:0]  out_rem,
	output logic [PW-1:0]          out_pay
);
	localparam int NS = (QW + BPS - 1) / BPS;

	logic                  vld_q [NS];
	logic [NL-1:0][VW-1:0] rem_q [NS];
	logic [NL-1:0][QW-1:0] dq_q  [NS];
	logic [NL-1:0][VW-1:0] dvs_q [NS];
	logic [PW-1:0]         pay_q [NS];

	for (genvar gs = 0; gs < NS; gs++) begin : g_st
		logic                  pv;
		logic [NL-1:0][VW-1:0] pr;
		logic [NL-1:0][QW-1:0] pq;
		logic [NL-1:0][VW-1:0] pd;
		logic [PW-1:0]         pp;
		logic [NL-1:0][VW-1:0] nr;
		logic [NL-1:0][QW-1:0] nq;

		if (gs == 0) begin : g_in
			assign pv = in_valid;
			assign pr = in_rem;
			assign pq = in_dq;
			assign pd = in_dvs;
			assign pp = in_pay;
		end else begin : g_prev
			assign pv = vld_q[gs-1];
			assign pr = rem_q[gs-1];
			assign pq = dq_q[gs-1];
			assign pd = dvs_q[gs-1];
			assign pp = pay_q[gs-1];
		end

		// BPS shift/compare/subtract steps; dividend bits leave the top of dq,
		// quotient bits enter at the bottom
		always_comb begin
			logic [VW:0]   t;
			logic [VW-1:0] r;
			logic [QW-1:0] q;
			logic          ge;
			for (int l = 0; l < NL; l++) begin
				r = pr[l];
				q = pq[l];
				for (int k = 0; k < BPS; k++) begin
					if (gs * BPS + k < QW) begin
						t  = {r, q[QW-1]};
						ge = (t >= {1'b0, pd[l]});
						r  = ge ? VW'(t - {1'b0, pd[l]}) : t[VW-1:0];
						q  = {q[QW-2:0], ge};
					end
				end
				nr[l] = r;
				nq[l] = q;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_q[gs] <= 1'b0;
			else
				vld_q[gs] <= pv;
		end

		always_ff @(posedge clk) begin
			rem_q[gs] <= nr;
			dq_q[gs]  <= nq;
			dvs_q[gs] <= pd;
			pay_q[gs] <= pp;
		end
	end

	assign out_valid = vld_q[NS-1];
	assign out_quo   = dq_q[NS-1];
	assign out_rem   = rem_q[NS-1];
	assign out_pay   = pay_q[NS-1];
endmodule

FILE: rtl/tauv_front.sv
// Front end: accepts tile ids, flags invalid requests, splits the index
// into column and row. Depends on tauv_pkg and tauv_div.
module tauv_front #(
	parameter int IDW    = tauv_pkg::DEF_TILE_ID_BITS,
	parameter int MAXDIM = tauv_pkg::DEF_MAX_TEXTURE_DIM,
	parameter int QDEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tauv_pkg::cfg_t                   cfg,
	input  logic                             in_valid,
	input  logic [IDW-1:0]                   tile_id,
	output logic                             full,
	input  logic [$clog2(QDEPTH+1)-1:0]      q_count,
	output logic                             out_valid,
	output logic                             out_bad,
	output logic [tauv_pkg::CFG_W-1:0]       out_col,
	output logic [IDW-1:0]                   out_row
);
	import tauv_pkg::*;

	localparam int CW    = $clog2(QDEPTH+1);
	localparam int CELLW = 2 * CFG_W;
	localparam int CMPW  = (IDW > CELLW) ? IDW : CELLW;
	localparam logic [16:0] MAXV = 17'(MAXDIM);

	logic [CELLW-1:0] cells_q;
	logic [CW-1:0]    cnt_q;
	logic             accept;
	logic             cfg_bad;
	logic             vld_s1;
	logic [IDW-1:0]   id_s1;
	logic             cfg_bad_s1;
	logic             bad_c;
	logic [IDW-1:0]   idx_c;

	// grid size, held for the id range check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cells_q <= '0;
		else
			cells_q <= cfg.grid_columns * cfg.grid_rows;
	end

	// request-independent reasons for an empty rectangle
	assign cfg_bad = (cfg.grid_columns == '0) || (cfg.grid_rows == '0) ||
		(cfg.tile_width == '0) || (cfg.tile_height == '0) ||
		(cfg.texture_width == '0) || (cfg.texture_height == '0) ||
		({2'b00, cfg.texture_width} > MAXV) || ({2'b00, cfg.texture_height} > MAXV);

	// credit: words in flight plus words queued never exceed the queue depth
	assign full   = ({1'b0, cnt_q} + {1'b0, q_count}) >= (CW+1)'(QDEPTH);
	assign accept = in_valid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (accept && !out_valid)
			cnt_q <= cnt_q + 1'b1;
		else if (!accept && out_valid)
			cnt_q <= cnt_q - 1'b1;
	end

	// stage 1: capture id
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		id_s1      <= tile_id;
		cfg_bad_s1 <= cfg_bad;
	end

	assign bad_c = cfg_bad_s1 || (id_s1 == '0) || (CMPW'(id_s1) > CMPW'(cells_q));
	assign idx_c = id_s1 - 1'b1;

	// index / columns: quotient is the row, remainder the column
	tauv_div #(
		.NL (1),
		.VW (CFG_W),
		.QW (IDW),
		.BPS(DIV_BPS),
		.PW (1)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s1),
		.in_rem   ('0),
		.in_dq    (idx_c),
		.in_dvs   (cfg.grid_columns),
		.in_pay   (bad_c),
		.out_valid(out_valid),
		.out_quo  (out_row),
		.out_rem  (out_col),
		.out_pay  (out_bad)
	);

`ifndef SYNTHESIS
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cnt_q} + {1'b0, q_count}) <= (CW+1)'(QDEPTH))
		else $error("front overcommitted the queue");
`endif
endmodule

FILE: rtl/tauv_back.sv
// Back end: pixel edges from column/row, bounds check, normalized edges.
// Depends on tauv_pkg and tauv_div.
module tauv_back #(
	parameter int IDW    = tauv_pkg::DEF_TILE_ID_BITS,
	parameter int FRAC   = tauv_pkg::DEF_FRACTION_BITS,
	parameter int QDEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  tauv_pkg::cfg_t                                cfg,
	input  logic                                          in_valid,
	input  logic                                          in_bad,
	input  logic [tauv_pkg::CFG_W-1:0]                    in_col,
	input  logic [IDW-1:0]                                in_row,
	output logic                                          in_pop,
	input  logic [$clog2(QDEPTH+1)-1:0]                   out_count,
	output logic                                          out_push,
	output logic [1+4*tauv_pkg::PX_W+4*(FRAC+1)-1:0]      out_word
);
	import tauv_pkg::*;

	localparam int CW  = $clog2(QDEPTH+1);
	localparam int UVW = FRAC + 1;
	localparam int PTW = CFG_W + 1;
	localparam int LPW = CFG_W + PTW;
	localparam int TPW = IDW + PTW;
	localparam int LW  = LPW + 1;
	localparam int TW  = TPW + 1;
	localparam int RW  = LW + 1;
	localparam int BW  = TW + 1;
	localparam int PAYW = 1 + 4 * PX_W;
	localparam int OW  = 1 + 4 * PX_W + 4 * UVW;

	logic [CW-1:0]  cnt_q;
	logic           vld_s1, vld_s2, vld_s3;
	logic           bad_s1, bad_s2, ok_s3;
	logic [LPW-1:0] lp_s1;
	logic [TPW-1:0] tp_s1;
	logic [LW-1:0]  left_s2;
	logic [TW-1:0]  top_s2;
	logic [RW-1:0]  right_c;
	logic [BW-1:0]  bottom_c;
	logic [PX_W-1:0] left_s3, top_s3, right_s3, bottom_s3;
	logic [3:0][TEX_W-1:0] n_rem;
	logic [3:0][UVW-1:0]   n_dq;
	logic [3:0][TEX_W-1:0] n_dvs;
	logic [3:0][UVW-1:0]   n_quo;
	logic [3:0][PX_W-1:0]  edges;
	logic [PAYW-1:0] pay_out;
	logic            div_valid;

	// credit against the result queue
	assign in_pop = in_valid && (({1'b0, cnt_q} + {1'b0, out_count}) < (CW+1)'(QDEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (in_pop && !div_valid)
			cnt_q <= cnt_q + 1'b1;
		else if (!in_pop && div_valid)
			cnt_q <= cnt_q - 1'b1;
	end

	// valid pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_pop;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// s1: offsets = index * pitch; s2: add margin; s3: far edges and bounds
	assign right_c  = RW'(left_s2) + RW'(cfg.tile_width);
	assign bottom_c = BW'(top_s2) + BW'(cfg.tile_height);

	always_ff @(posedge clk) begin
		bad_s1    <= in_bad;
		lp_s1     <= LPW'(in_col * (PTW'(cfg.tile_width) + PTW'(cfg.tile_gap)));
		tp_s1     <= TPW'(in_row * (PTW'(cfg.tile_height) + PTW'(cfg.tile_gap)));
		bad_s2    <= bad_s1;
		left_s2   <= LW'(lp_s1) + LW'(cfg.edge_margin);
		top_s2    <= TW'(tp_s1) + TW'(cfg.edge_margin);
		ok_s3     <= !bad_s2 && (right_c <= RW'(cfg.texture_width)) &&
			(bottom_c <= BW'(cfg.texture_height));
		left_s3   <= left_s2[PX_W-1:0];
		top_s3    <= top_s2[PX_W-1:0];
		right_s3  <= right_c[PX_W-1:0];
		bottom_s3 <= bottom_c[PX_W-1:0];
	end

	// lanes: left, top, right, bottom; an edge never exceeds its size on a
	// valid word, so edge>>1 is a legal starting remainder
	assign edges = {bottom_s3, right_s3, top_s3, left_s3};
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			n_rem[l] = TEX_W'(edges[l][PX_W-1:1]);
			n_dq[l]  = {edges[l][0], FRAC'(0)};
			n_dvs[l] = (l == 0 || l == 2) ? cfg.texture_width : cfg.texture_height;
		end
	end

	tauv_div #(
		.NL (4),
		.VW (TEX_W),
		.QW (UVW),
		.BPS(DIV_BPS),
		.PW (PAYW)
	) u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s3),
		.in_rem   (n_rem),
		.in_dq    (n_dq),
		.in_dvs   (n_dvs),
		.in_pay   ({ok_s3, left_s3, top_s3, right_s3, bottom_s3}),
		.out_valid(div_valid),
		.out_quo  (n_quo),
		.out_rem  (),
		.out_pay  (pay_out)
	);

	// invalid words leave as all zero
	assign out_push = div_valid;
	assign out_word = pay_out[PAYW-1] ?
		{pay_out, n_quo[0], n_quo[1], n_quo[2], n_quo[3]} : OW'(0);

`ifndef SYNTHESIS
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cnt_q} + {1'b0, out_count}) <= (CW+1)'(QDEPTH))
		else $error("back overcommitted the result queue");
`endif
endmodule

FILE: rtl/tile_atlas_uv_rect.sv
// Top level: register port, front end, id queue, back end, result queue.
// Depends on tauv_pkg, tauv_front, tauv_back, tauv_fifo.
//
//  channel  | ports                               | accepted when
//  ---------+-------------------------------------+--------------------------
//  request  | push, full, tile_id                 | push & !full
//  result   | pop, empty, tile_ok..v_bottom       | pop & !empty
//  config   | psel penable pwrite paddr pwdata    | psel & penable & pwrite
//
// One id per cycle sustained while full stays low. Ids pass through the front
// (id capture, then the column/row divider, 2 bits a stage), the id queue,
// then the back (offset, margin and far-edge stages, four normalizing lanes).
// full rises only when the id queue and front pipe together hold its depth;
// the back stalls only on the result queue. Reset clears registers and queues.
module tile_atlas_uv_rect #(
	parameter int TILE_ID_BITS    = tauv_pkg::DEF_TILE_ID_BITS,
	parameter int MAX_TEXTURE_DIM = tauv_pkg::DEF_MAX_TEXTURE_DIM,
	parameter int FRACTION_BITS   = tauv_pkg::DEF_FRACTION_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tauv_pkg::APB_AW-1:0]   paddr,
	input  logic [tauv_pkg::APB_DW-1:0]   pwdata,
	output logic [tauv_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	input  logic                          push,
	output logic                          full,
	input  logic [TILE_ID_BITS-1:0]       tile_id,
	input  logic                          pop,
	output logic                          empty,
	output logic                          tile_ok,
	output logic [tauv_pkg::PX_W-1:0]     left_px,
	output logic [tauv_pkg::PX_W-1:0]     top_px,
	output logic [tauv_pkg::PX_W-1:0]     right_px,
	output logic [tauv_pkg::PX_W-1:0]     bottom_px,
	output logic [FRACTION_BITS:0]        u_left,
	output logic [FRACTION_BITS:0]        v_top,
	output logic [FRACTION_BITS:0]        u_right,
	output logic [FRACTION_BITS:0]        v_bottom
);
	import tauv_pkg::*;

	localparam int UVW       = FRACTION_BITS + 1;
	localparam int FRONT_LAT = 1 + (TILE_ID_BITS + DIV_BPS - 1) / DIV_BPS;
	localparam int BACK_LAT  = 3 + (UVW + DIV_BPS - 1) / DIV_BPS;
	localparam int MID_DEPTH = 2 ** $clog2(FRONT_LAT + 2);
	localparam int OUT_DEPTH = 2 ** $clog2(BACK_LAT + 2);
	localparam int MID_W     = 1 + CFG_W + TILE_ID_BITS;
	localparam int OUT_W     = 1 + 4 * PX_W + 4 * UVW;

	cfg_t cfg_q;
	logic wr_en;
	logic [2:0] reg_idx;

	logic                            f_valid, f_bad;
	logic [CFG_W-1:0]                f_col;
	logic [TILE_ID_BITS-1:0]         f_row;
	logic [$clog2(MID_DEPTH+1)-1:0]  mid_count;
	logic [MID_W-1:0]                mid_dout;
	logic                            mid_pop;
	logic [$clog2(OUT_DEPTH+1)-1:0]  out_count;
	logic                            out_push;
	logic [OUT_W-1:0]                out_word;
	logic [OUT_W-1:0]                out_dout;
	logic                            out_pop;

	// register port
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_TILE_WIDTH:     cfg_q.tile_width     <= pwdata[CFG_W-1:0];
				REG_TILE_HEIGHT:    cfg_q.tile_height    <= pwdata[CFG_W-1:0];
				REG_GRID_COLUMNS:   cfg_q.grid_columns   <= pwdata[CFG_W-1:0];
				REG_GRID_ROWS:      cfg_q.grid_rows      <= pwdata[CFG_W-1:0];
				REG_EDGE_MARGIN:    cfg_q.edge_margin    <= pwdata[CFG_W-1:0];
				REG_TILE_GAP:       cfg_q.tile_gap       <= pwdata[CFG_W-1:0];
				REG_TEXTURE_WIDTH:  cfg_q.texture_width  <= pwdata[TEX_W-1:0];
				REG_TEXTURE_HEIGHT: cfg_q.texture_height <= pwdata[TEX_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			REG_TILE_WIDTH:     prdata = APB_DW'(cfg_q.tile_width);
			REG_TILE_HEIGHT:    prdata = APB_DW'(cfg_q.tile_height);
			REG_GRID_COLUMNS:   prdata = APB_DW'(cfg_q.grid_columns);
			REG_GRID_ROWS:      prdata = APB_DW'(cfg_q.grid_rows);
			REG_EDGE_MARGIN:    prdata = APB_DW'(cfg_q.edge_margin);
			REG_TILE_GAP:       prdata = APB_DW'(cfg_q.tile_gap);
			REG_TEXTURE_WIDTH:  prdata = APB_DW'(cfg_q.texture_width);
			REG_TEXTURE_HEIGHT: prdata = APB_DW'(cfg_q.texture_height);
			default:            prdata = '0;
		endcase
	end

	// front end
	tauv_front #(
		.IDW   (TILE_ID_BITS),
		.MAXDIM(MAX_TEXTURE_DIM),
		.QDEPTH(MID_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (push),
		.tile_id  (tile_id),
		.full     (full),
		.q_count  (mid_count),
		.out_valid(f_valid),
		.out_bad  (f_bad),
		.out_col  (f_col),
		.out_row  (f_row)
	);

	// queue between front and back
	tauv_fifo #(
		.W    (MID_W),
		.DEPTH(MID_DEPTH)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (f_valid),
		.din   ({f_bad, f_col, f_row}),
		.pop   (mid_pop),
		.dout  (mid_dout),
		.count (mid_count)
	);

	// back end
	tauv_back #(
		.IDW   (TILE_ID_BITS),
		.FRAC  (FRACTION_BITS),
		.QDEPTH(OUT_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (mid_count != '0),
		.in_bad   (mid_dout[MID_W-1]),
		.in_col   (mid_dout[MID_W-2 -: CFG_W]),
		.in_row   (mid_dout[TILE_ID_BITS-1:0]),
		.in_pop   (mid_pop),
		.out_count(out_count),
		.out_push (out_push),
		.out_word (out_word)
	);

	// result queue
	assign out_pop = pop && !empty;

	tauv_fifo #(
		.W    (OUT_W),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.din   (out_word),
		.pop   (out_pop),
		.dout  (out_dout),
		.count (out_count)
	);

	assign empty = (out_count == '0);
	assign {tile_ok, left_px, top_px, right_px, bottom_px,
		u_left, v_top, u_right, v_bottom} = out_dout;

`ifndef SYNTHESIS
	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !tile_ok) |-> (left_px == '0 && bottom_px == '0 &&
			u_left == '0 && v_bottom == '0))
		else $error("invalid word carries nonzero fields");
`endif
endmodule
